// ----- design/slpg_pkg.sv -----
// Shared types, codes and constants of the status LED pattern generator.
`default_nettype none

package slpg_pkg;

    // Width of the timing registers and of the command payload fields.
    localparam int REG_WIDTH           = 12;
    localparam int CMD_WIDTH           = 2;
    localparam int PAT_WIDTH           = 3;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int COUNT_WIDTH_DEFAULT = 12;

    // Blip re-check interval in milliseconds.
    localparam int RECHECK_MS = 10;

    // Register reset values.
    localparam logic [REG_WIDTH-1:0] SLOW_HALF_RESET = REG_WIDTH'(500);
    localparam logic [REG_WIDTH-1:0] FAST_HALF_RESET = REG_WIDTH'(100);
    localparam logic [REG_WIDTH-1:0] BEAT_ON_RESET   = REG_WIDTH'(50);
    localparam logic [REG_WIDTH-1:0] BEAT_OFF_RESET  = REG_WIDTH'(1950);
    localparam logic [REG_WIDTH-1:0] BLIP_RESET      = REG_WIDTH'(50);

    // Command codes of an input item.
    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_BLIP = 2'd2
    } cmd_t;

    // Pattern codes.
    typedef enum logic [PAT_WIDTH-1:0] {
        PAT_OFF   = 3'd0,
        PAT_ON    = 3'd1,
        PAT_SLOW  = 3'd2,
        PAT_FAST  = 3'd3,
        PAT_HEART = 3'd4
    } pattern_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ENABLED     = 3'd0,
        CFG_ACTIVE_HIGH = 3'd1,
        CFG_SLOW_HALF   = 3'd2,
        CFG_FAST_HALF   = 3'd3,
        CFG_BEAT_ON     = 3'd4,
        CFG_BEAT_OFF    = 3'd5,
        CFG_BLIP        = 3'd6
    } cfg_index_t;

    // Configuration handed from the register file to the engine.
    typedef struct packed {
        logic                 enabled;
        logic                 active_high;
        logic [REG_WIDTH-1:0] slow_half_ms;
        logic [REG_WIDTH-1:0] fast_half_ms;
        logic [REG_WIDTH-1:0] beat_on_ms;
        logic [REG_WIDTH-1:0] beat_off_ms;
        logic [REG_WIDTH-1:0] blip_ms;
    } cfg_t;

endpackage

`default_nettype wire

// ----- design/slpg_if.sv -----
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface slpg_in_if;
    logic                            valid;
    logic                            ready;
    logic [slpg_pkg::CMD_WIDTH-1:0]  command;
    logic [slpg_pkg::PAT_WIDTH-1:0]  pattern;

    modport source (output valid, output command, output pattern, input ready);
    modport sink   (input valid, input command, input pattern, output ready);
endinterface

interface slpg_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic led_lit;
    logic timer_running;

    modport source (output valid, output pin_level, output led_lit,
                    output timer_running, input ready);
    modport sink   (input valid, input pin_level, input led_lit,
                    input timer_running, output ready);
endinterface

`default_nettype wire

// ----- design/slpg_cfg_regs.sv -----
// Configuration register file of the status LED pattern generator.
`default_nettype none

module slpg_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [slpg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [slpg_pkg::REG_WIDTH-1:0]       cfg_data,
    output slpg_pkg::cfg_t                            cfg
);

    slpg_pkg::cfg_t cfg_reg;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled      <= 1'b0;
            cfg_reg.active_high  <= 1'b1;
            cfg_reg.slow_half_ms <= slpg_pkg::SLOW_HALF_RESET;
            cfg_reg.fast_half_ms <= slpg_pkg::FAST_HALF_RESET;
            cfg_reg.beat_on_ms   <= slpg_pkg::BEAT_ON_RESET;
            cfg_reg.beat_off_ms  <= slpg_pkg::BEAT_OFF_RESET;
            cfg_reg.blip_ms      <= slpg_pkg::BLIP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slpg_pkg::CFG_ENABLED:     cfg_reg.enabled      <= cfg_data[0];
                slpg_pkg::CFG_ACTIVE_HIGH: cfg_reg.active_high  <= cfg_data[0];
                slpg_pkg::CFG_SLOW_HALF:   cfg_reg.slow_half_ms <= cfg_data;
                slpg_pkg::CFG_FAST_HALF:   cfg_reg.fast_half_ms <= cfg_data;
                slpg_pkg::CFG_BEAT_ON:     cfg_reg.beat_on_ms   <= cfg_data;
                slpg_pkg::CFG_BEAT_OFF:    cfg_reg.beat_off_ms  <= cfg_data;
                slpg_pkg::CFG_BLIP:        cfg_reg.blip_ms      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/slpg_engine.sv -----
// Input register, LED pattern state update and result register.
`default_nettype none

module slpg_engine #(
    parameter int COUNT_WIDTH = slpg_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire slpg_pkg::cfg_t cfg,
    slpg_in_if.sink             req,
    slpg_out_if.source          rsp
);

    localparam int WIDE = (COUNT_WIDTH > slpg_pkg::REG_WIDTH) ? COUNT_WIDTH
                                                              : slpg_pkg::REG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE     = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] RECHECK_COUNT = COUNT_WIDTH'(slpg_pkg::RECHECK_MS);

    // Clamp a loaded period to the counter range.
    function automatic logic [COUNT_WIDTH-1:0] cap_count(
        input logic [slpg_pkg::REG_WIDTH-1:0] v
    );
        logic [WIDE-1:0] wide_v;
        wide_v = WIDE'(v);
        if (wide_v > WIDE'(COUNT_MAX))
            return COUNT_MAX;
        else
            return COUNT_WIDTH'(wide_v);
    endfunction

    // Input stage.
    logic                           s1_valid_reg;
    logic [slpg_pkg::CMD_WIDTH-1:0] cmd_reg;
    logic [slpg_pkg::PAT_WIDTH-1:0] pat_reg;
    logic                           s1_advance;

    // Pattern state.
    logic [slpg_pkg::PAT_WIDTH-1:0] pattern_reg, pattern_next;
    logic                           phase_reg, phase_next;
    logic                           armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0]         left_reg, left_next;
    logic [COUNT_WIDTH-1:0]         blip_reg, blip_next;
    logic                           lit_reg, lit_next;

    // Result stage.
    logic out_valid_reg;
    logic pin_reg, pin_next;
    logic led_reg;
    logic run_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;

    // Input register: holds one item until the result slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            cmd_reg <= req.command;
            pat_reg <= req.pattern;
        end
    end

    // Next pattern state for the item in the input register.
    always_comb
    begin
        pattern_next = pattern_reg;
        phase_next   = phase_reg;
        armed_next   = armed_reg;
        left_next    = left_reg;
        blip_next    = blip_reg;
        lit_next     = lit_reg;
        unique case (cmd_reg)
            slpg_pkg::CMD_TICK:
            begin
                if (blip_reg != '0)
                    blip_next = blip_reg - COUNT_ONE;
                if (armed_reg)
                begin
                    if (left_reg <= COUNT_ONE)
                    begin
                        // Countdown expired: a running blip wins over the pattern.
                        armed_next = 1'b0;
                        if (blip_next != '0)
                        begin
                            if (cfg.enabled)
                                lit_next = 1'b1;
                            armed_next = 1'b1;
                            left_next  = RECHECK_COUNT;
                        end
                        else
                        begin
                            case (pattern_reg)
                                slpg_pkg::PAT_OFF:
                                begin
                                    if (cfg.enabled)
                                        lit_next = 1'b0;
                                end
                                slpg_pkg::PAT_ON:
                                begin
                                    if (cfg.enabled)
                                        lit_next = 1'b1;
                                end
                                slpg_pkg::PAT_SLOW:
                                begin
                                    phase_next = ~phase_reg;
                                    if (cfg.enabled)
                                        lit_next = ~phase_reg;
                                    armed_next = 1'b1;
                                    left_next  = cap_count(cfg.slow_half_ms);
                                end
                                slpg_pkg::PAT_FAST:
                                begin
                                    phase_next = ~phase_reg;
                                    if (cfg.enabled)
                                        lit_next = ~phase_reg;
                                    armed_next = 1'b1;
                                    left_next  = cap_count(cfg.fast_half_ms);
                                end
                                slpg_pkg::PAT_HEART:
                                begin
                                    // Heartbeat alternates a short lit and a long dark time.
                                    phase_next = ~phase_reg;
                                    if (cfg.enabled)
                                        lit_next = ~phase_reg;
                                    armed_next = 1'b1;
                                    left_next  = phase_reg ? cap_count(cfg.beat_off_ms)
                                                           : cap_count(cfg.beat_on_ms);
                                end
                                default: ;
                            endcase
                        end
                    end
                    else
                        left_next = left_reg - COUNT_ONE;
                end
            end
            slpg_pkg::CMD_SET:
            begin
                if (cfg.enabled)
                begin
                    pattern_next = pat_reg;
                    phase_next   = 1'b0;
                    armed_next   = 1'b1;
                    left_next    = COUNT_ONE;
                end
            end
            slpg_pkg::CMD_BLIP:
            begin
                if (cfg.enabled)
                begin
                    blip_next  = cap_count(cfg.blip_ms);
                    armed_next = 1'b1;
                    left_next  = COUNT_ONE;
                end
            end
            default: ;
        endcase
        pin_next = cfg.enabled && (lit_next == cfg.active_high);
    end

    // Pattern state registers, updated as an item moves to the result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= slpg_pkg::PAT_OFF;
            phase_reg   <= 1'b0;
            armed_reg   <= 1'b0;
            left_reg    <= '0;
            blip_reg    <= '0;
            lit_reg     <= 1'b0;
        end
        else if (s1_advance)
        begin
            pattern_reg <= pattern_next;
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            left_reg    <= left_next;
            blip_reg    <= blip_next;
            lit_reg     <= lit_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pin_reg <= pin_next;
            led_reg <= lit_next;
            run_reg <= armed_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.pin_level     = pin_reg;
    assign rsp.led_lit       = led_reg;
    assign rsp.timer_running = run_reg;

    // An item waiting in the input stage is never dropped.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("input stage item lost");

    // A set command taken while enabled always reports a running timer.
    a_set_arms: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && cfg.enabled && (cmd_reg == slpg_pkg::CMD_SET)
        |=> out_valid_reg && run_reg && armed_reg)
        else $error("set command did not arm the countdown");

    // A tick cannot arm an idle countdown.
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !armed_reg && (cmd_reg == slpg_pkg::CMD_TICK) |=> !armed_reg)
        else $error("tick armed an idle countdown");

    // While disabled the LED state is frozen and the pin stays low.
    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !cfg.enabled |=> $stable(lit_reg) && !pin_reg)
        else $error("disabled block changed the LED");

endmodule

`default_nettype wire

// ----- design/status_led_pattern_generator_core.sv -----
// Top level of the status LED pattern generator.
//
// Usage: command items arrive on the req channel (valid/ready): a one
// millisecond tick, a set-pattern command carrying a pattern code, or a blip.
// Every accepted item produces exactly one result item on the rsp channel
// with the pin level, the logical LED state and whether a countdown is armed,
// all taken after the item has been applied.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// one register per cycle, while no item is in flight.
// Path: an accepted item is held in the input register, then moves to the
// result register, which holds its result until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall; the
// state update is a single pass of countdown and pattern logic between the
// input and result registers.
// Reset clears the pattern state, both valid flags and loads the register
// defaults; the block is disabled after reset.
// When the receiver stalls, the result register holds its item and the input
// register takes one more; after that req.ready drops until rsp drains.
`default_nettype none

module status_led_pattern_generator_core #(
    parameter int COUNT_WIDTH = slpg_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    slpg_in_if.sink                                   req,
    slpg_out_if.source                                rsp,
    input  wire logic                                 cfg_we,
    input  wire logic [slpg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [slpg_pkg::REG_WIDTH-1:0]       cfg_data
);

    slpg_pkg::cfg_t cfg;

    // Configuration registers.
    slpg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pattern engine.
    slpg_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ----- verif/status_led_pattern_generator_core_test.sv -----
// Self-checking testbench of the status LED pattern generator core.
`timescale 1ns / 1ps

module status_led_pattern_generator_core_test;
    import slpg_pkg::*;

    // Command code with no meaning and the highest pattern code the field can carry.
    localparam logic [CMD_WIDTH-1:0] CMD_NONE      = 2'd3;
    localparam logic [PAT_WIDTH-1:0] PAT_LAST_CODE = 3'd7;

    // Short periods that let patterns expire often within a phase.
    localparam int SHORT_PERIOD_MAX = 12;
    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_ITEMS      = 88;
    localparam int HOLD_CYCLES      = 300;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] command;
        logic [PAT_WIDTH-1:0] pattern;
    } cmd_item_t;

    typedef struct packed {
        logic pin_level;
        logic led_lit;
        logic timer_running;
    } led_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [REG_WIDTH-1:0]       cfg_data;

    slpg_in_if  req_ch ();
    slpg_out_if rsp_ch ();

    status_led_pattern_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cmd_item_t   pending_items[$];
    led_result_t expected_leds[$];
    int          error_count    = 0;
    int          items_accepted = 0;
    logic        hold_rsp;

    // Register copies kept by the predictor.
    logic                 reg_enabled;
    logic                 reg_active_high;
    logic [REG_WIDTH-1:0] reg_slow_half;
    logic [REG_WIDTH-1:0] reg_fast_half;
    logic [REG_WIDTH-1:0] reg_beat_on;
    logic [REG_WIDTH-1:0] reg_beat_off;
    logic [REG_WIDTH-1:0] reg_blip;

    // Pattern state kept by the predictor.
    logic [PAT_WIDTH-1:0] led_pattern;
    logic                 led_phase;
    logic                 countdown_on;
    logic [REG_WIDTH-1:0] countdown_ms;
    logic [REG_WIDTH-1:0] blip_ms_left;
    logic                 led_on;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The register width equals the counter width, so a loaded period never needs capping.
    function automatic void load_countdown(logic [REG_WIDTH-1:0] ms);
        countdown_on = 1'b1;
        countdown_ms = ms;
    endfunction

    // A disabled block keeps the LED where it is.
    function automatic void set_led(logic lit);
        if (reg_enabled)
            led_on = lit;
    endfunction

    // Runs the pattern rule once the countdown has run out.
    function automatic void expire_countdown();
        countdown_on = 1'b0;
        if (blip_ms_left != 0)
        begin
            set_led(1'b1);
            load_countdown(REG_WIDTH'(RECHECK_MS));
        end
        else
        begin
            case (led_pattern)
                PAT_OFF: set_led(1'b0);
                PAT_ON:  set_led(1'b1);
                PAT_SLOW:
                begin
                    led_phase = ~led_phase;
                    set_led(led_phase);
                    load_countdown(reg_slow_half);
                end
                PAT_FAST:
                begin
                    led_phase = ~led_phase;
                    set_led(led_phase);
                    load_countdown(reg_fast_half);
                end
                PAT_HEART:
                begin
                    if (led_phase)
                    begin
                        set_led(1'b0);
                        led_phase = 1'b0;
                        load_countdown(reg_beat_off);
                    end
                    else
                    begin
                        set_led(1'b1);
                        led_phase = 1'b1;
                        load_countdown(reg_beat_on);
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // Applies one command item and returns the LED status it leaves behind.
    function automatic led_result_t advance_led(cmd_item_t item);
        led_result_t res;
        if (item.command == CMD_TICK)
        begin
            if (blip_ms_left != 0)
                blip_ms_left = blip_ms_left - 1'b1;
            if (countdown_on)
            begin
                if (countdown_ms <= 1)
                    expire_countdown();
                else
                    countdown_ms = countdown_ms - 1'b1;
            end
        end
        else if (item.command == CMD_SET)
        begin
            if (reg_enabled)
            begin
                led_pattern = item.pattern;
                led_phase   = 1'b0;
                load_countdown(REG_WIDTH'(1));
            end
        end
        else if (item.command == CMD_BLIP)
        begin
            if (reg_enabled)
            begin
                blip_ms_left = reg_blip;
                load_countdown(REG_WIDTH'(1));
            end
        end
        res.pin_level     = reg_enabled ? (led_on == reg_active_high) : 1'b0;
        res.led_lit       = led_on;
        res.timer_running = countdown_on;
        return res;
    endfunction

    function automatic logic idle_roll();
        if (items_accepted >= 700 && items_accepted < 900)
            return 1'b0;
        return $urandom_range(0, 99) < 9;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic push_item(logic [CMD_WIDTH-1:0] command, logic [PAT_WIDTH-1:0] pattern);
        cmd_item_t item;
        item.command = command;
        item.pattern = pattern;
        pending_items.push_back(item);
    endtask

    // Waits until every item has come back, then lets the pipeline drain.
    task automatic settle();
        while (pending_items.size() != 0 || expected_leds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [REG_WIDTH-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ENABLED:     reg_enabled     = data[0];
            CFG_ACTIVE_HIGH: reg_active_high = data[0];
            CFG_SLOW_HALF:   reg_slow_half   = data;
            CFG_FAST_HALF:   reg_fast_half   = data;
            CFG_BEAT_ON:     reg_beat_on     = data;
            CFG_BEAT_OFF:    reg_beat_off    = data;
            CFG_BLIP:        reg_blip        = data;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Kind 0 gives the longest period, 1 the shortest (zero included), 2 any value, any other kind a short one.
    function automatic logic [REG_WIDTH-1:0] pick_period(int kind);
        case (kind)
            0:       return '1;
            1:       return REG_WIDTH'($urandom_range(0, 1));
            2:       return REG_WIDTH'($urandom());
            default: return REG_WIDTH'($urandom_range(1, SHORT_PERIOD_MAX));
        endcase
    endfunction

    task automatic configure_phase(int phase);
        int   kind;
        logic en;
        logic polarity;
        kind     = (phase < 2) ? phase : $urandom_range(0, 9);
        en       = (phase == 3) ? 1'b0 : ($urandom_range(0, 99) < 85);
        polarity = (phase < 2) ? phase[0] : 1'($urandom());
        // Upper data bits of the one-bit registers are don't-care.
        write_reg(CFG_ENABLED, (REG_WIDTH'($urandom()) & ~REG_WIDTH'(1)) | en);
        write_reg(CFG_ACTIVE_HIGH, (REG_WIDTH'($urandom()) & ~REG_WIDTH'(1)) | polarity);
        write_reg(CFG_SLOW_HALF, pick_period(kind));
        write_reg(CFG_FAST_HALF, pick_period(kind));
        write_reg(CFG_BEAT_ON, pick_period(kind));
        write_reg(CFG_BEAT_OFF, pick_period(kind));
        write_reg(CFG_BLIP, pick_period(kind));
        close_writes();
    endtask

    // A set command first, then mostly ticks with commands and noise mixed in.
    task automatic fill_phase(int count);
        int                   roll;
        logic [CMD_WIDTH-1:0] command;
        logic [PAT_WIDTH-1:0] pattern;
        push_item(CMD_SET, PAT_WIDTH'($urandom_range(PAT_OFF, PAT_HEART)));
        for (int i = 1; i < count; i++)
        begin
            roll    = $urandom_range(0, 99);
            pattern = PAT_WIDTH'($urandom());
            if (roll < 78)
                command = CMD_TICK;
            else if (roll < 86)
            begin
                command = CMD_SET;
                if ($urandom_range(0, 99) < 80)
                    pattern = PAT_WIDTH'($urandom_range(PAT_OFF, PAT_HEART));
            end
            else if (roll < 93)
                command = CMD_BLIP;
            else
                command = CMD_WIDTH'($urandom());
            push_item(command, pattern);
        end
    endtask

    // Driver: presents pending items and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_leds.push_back(advance_led(pending_items.pop_front()));
                items_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_items.size() != 0 && !idle_roll())
                begin
                    req_ch.valid   <= 1'b1;
                    req_ch.command <= pending_items[0].command;
                    req_ch.pattern <= pending_items[0].pattern;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        led_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_leds.size() == 0)
                    report_mismatch("result with no item pending", rsp_ch.led_lit, 0);
                else
                begin
                    want = expected_leds.pop_front();
                    if (rsp_ch.pin_level !== want.pin_level)
                        report_mismatch("pin_level", rsp_ch.pin_level, want.pin_level);
                    if (rsp_ch.led_lit !== want.led_lit)
                        report_mismatch("led_lit", rsp_ch.led_lit, want.led_lit);
                    if (rsp_ch.timer_running !== want.timer_running)
                        report_mismatch("timer_running", rsp_ch.timer_running,
                                        want.timer_running);
                end
            end
            rsp_ch.ready <= !hold_rsp && !idle_roll();
        end
    end

    // One long receiver stall while the sender still has items to offer.
    initial
    begin
        hold_rsp = 1'b0;
        while (!(items_accepted >= 400 && pending_items.size() >= 10))
            @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Stimulus: reset, directed items, then randomly configured phases.
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ENABLED;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_TICK;
        req_ch.pattern = PAT_OFF;
        rsp_ch.ready   = 1'b0;

        reg_enabled     = 1'b0;
        reg_active_high = 1'b1;
        reg_slow_half   = SLOW_HALF_RESET;
        reg_fast_half   = FAST_HALF_RESET;
        reg_beat_on     = BEAT_ON_RESET;
        reg_beat_off    = BEAT_OFF_RESET;
        reg_blip        = BLIP_RESET;
        led_pattern     = PAT_OFF;
        led_phase       = 1'b0;
        countdown_on    = 1'b0;
        countdown_ms    = '0;
        blip_ms_left    = '0;
        led_on          = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Commands are ignored while the block is disabled after reset.
        push_item(CMD_SET, PAT_SLOW);
        push_item(CMD_BLIP, PAT_OFF);
        push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_NONE, PAT_LAST_CODE);
        settle();

        write_reg(CFG_ENABLED, REG_WIDTH'(1));
        write_reg(CFG_ACTIVE_HIGH, REG_WIDTH'(0));
        write_reg(CFG_SLOW_HALF, REG_WIDTH'(2));
        write_reg(CFG_FAST_HALF, REG_WIDTH'(1));
        write_reg(CFG_BEAT_ON, REG_WIDTH'(1));
        write_reg(CFG_BEAT_OFF, REG_WIDTH'(3));
        write_reg(CFG_BLIP, REG_WIDTH'(3));
        close_writes();

        // Every pattern, a blip, and a pattern code with no rule behind it.
        push_item(CMD_SET, PAT_OFF);
        push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_SET, PAT_ON);
        push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_SET, PAT_SLOW);
        repeat (3) push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_SET, PAT_FAST);
        repeat (2) push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_SET, PAT_HEART);
        repeat (3) push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_BLIP, PAT_OFF);
        repeat (3) push_item(CMD_TICK, PAT_OFF);
        push_item(CMD_SET, PAT_LAST_CODE);
        repeat (2) push_item(CMD_TICK, PAT_OFF);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            configure_phase(p);
            fill_phase(PHASE_ITEMS);
        end

        settle();
        repeat (8) @(posedge clk);
        if (expected_leds.size() != 0)
            report_mismatch("results never arrived", 0, expected_leds.size());
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Guard against a block that stops answering.
    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
